// ----- rtl/core/shlex_pkg.sv -----
package shlex_pkg;

  // Byte codes the lexer reacts to.
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PRN_LO = 8'h20;
  localparam logic [7:0] CH_PRN_HI = 8'h7E;

  // Number of result bundles held between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    EV_VALUE  = 2'd0,
    EV_CLOSE  = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_ERROR  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    KIND_QUOTED = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_OPER   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MULTI   = 2'd0,
    ERR_OPERAND = 2'd1,
    ERR_QUOTE   = 2'd2,
    ERR_NPRINT  = 2'd3
  } err_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  value_byte;
    kind_t       kind;
    err_t        err;
  } res_t;

  // All results caused by one input byte; count is 1 to 3, slot 0 goes out first.
  typedef struct packed {
    logic [1:0]      count;
    res_t [2:0]      slot;
  } bundle_t;

  function automatic res_t mk_res(event_t ev, logic [7:0] val, kind_t k, err_t e);
    res_t r;
    r.ev         = ev;
    r.value_byte = val;
    r.kind       = k;
    r.err        = e;
    return r;
  endfunction

endpackage

// ----- rtl/core/shlex_if.sv -----
interface shlex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source(output valid, output char_in, input ready);
  modport sink(input valid, input char_in, output ready);
endinterface

interface shlex_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] value_byte;
  logic [1:0] token_kind;
  logic [1:0] error_code;
  logic       last;

  modport source(output valid, output event_res, output value_byte, output token_kind,
                 output error_code, output last, input ready);
  modport sink(input valid, input event_res, input value_byte, input token_kind,
               input error_code, input last, output ready);
endinterface

// ----- rtl/core/shlex_front.sv -----
module shlex_front (
  input  logic              clk,
  input  logic              rst,
  shlex_char_if.sink        chars,
  input  logic              full,
  output logic              push,
  output shlex_pkg::bundle_t push_data
);
  import shlex_pkg::*;

  typedef enum logic [2:0] {
    ST_START = 3'b001,
    ST_QUOTE = 3'b010,
    ST_WORD  = 3'b100
  } mode_t;

  mode_t      mode, mode_next;
  logic       seen_pipe, seen_pipe_next;
  logic       seen_out_redirect, seen_out_redirect_next;
  logic       have_operand, have_operand_next;
  logic       discard_to_eol, discard_to_eol_next;
  logic       line_reset;
  logic       accept;
  logic [7:0] c;
  logic       is_eol, is_prn, is_blank, is_oper;
  bundle_t    bundle;

  assign c        = chars.char_in;
  assign is_eol   = (c == CH_LF) || (c == CH_NUL);
  assign is_prn   = (c >= CH_PRN_LO) && (c <= CH_PRN_HI);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                    (c == CH_FF) || (c == CH_CR);
  assign is_oper  = (c == CH_PIPE) || (c == CH_GT) || (c == CH_LT);

  assign chars.ready = !full;
  assign accept      = chars.valid && !full;
  assign push        = accept && (bundle.count != 2'd0);
  assign push_data   = bundle;

  always_comb begin
    mode_next              = mode;
    seen_pipe_next         = seen_pipe;
    seen_out_redirect_next = seen_out_redirect;
    have_operand_next      = have_operand;
    discard_to_eol_next    = discard_to_eol;
    line_reset             = 1'b0;
    bundle                 = '0;

    if (discard_to_eol) begin
      if (is_eol) begin
        discard_to_eol_next = 1'b0;
        line_reset          = 1'b1;
      end
    end else begin
      unique case (mode)
        ST_QUOTE: begin
          if (c == CH_DQUOTE) begin
            bundle.count      = 2'd1;
            bundle.slot[0]    = mk_res(EV_CLOSE, 8'h00, KIND_QUOTED, ERR_MULTI);
            have_operand_next = 1'b1;
            mode_next         = ST_START;
          end else if (is_prn) begin
            bundle.count   = 2'd1;
            bundle.slot[0] = mk_res(EV_VALUE, c, KIND_QUOTED, ERR_MULTI);
          end else begin
            bundle.count        = 2'd1;
            bundle.slot[0]      = mk_res(EV_ERROR, 8'h00, KIND_QUOTED,
                                         is_eol ? ERR_QUOTE : ERR_NPRINT);
            line_reset          = 1'b1;
            discard_to_eol_next = !is_eol;
          end
        end
        ST_WORD: begin
          if (is_eol) begin
            bundle.count   = 2'd2;
            bundle.slot[0] = mk_res(EV_CLOSE, 8'h00, KIND_WORD, ERR_MULTI);
            bundle.slot[1] = mk_res(EV_ACCEPT, 8'h00, KIND_QUOTED, ERR_MULTI);
            line_reset     = 1'b1;
          end else if (is_blank) begin
            bundle.count      = 2'd1;
            bundle.slot[0]    = mk_res(EV_CLOSE, 8'h00, KIND_WORD, ERR_MULTI);
            have_operand_next = 1'b1;
            mode_next         = ST_START;
          end else if (is_oper) begin
            if ((c == CH_PIPE) && seen_out_redirect) begin
              bundle.count        = 2'd1;
              bundle.slot[0]      = mk_res(EV_ERROR, 8'h00, KIND_QUOTED, ERR_OPERAND);
              line_reset          = 1'b1;
              discard_to_eol_next = 1'b1;
            end else if ((c == CH_LT) && seen_pipe) begin
              bundle.count        = 2'd1;
              bundle.slot[0]      = mk_res(EV_ERROR, 8'h00, KIND_QUOTED, ERR_MULTI);
              line_reset          = 1'b1;
              discard_to_eol_next = 1'b1;
            end else begin
              // The open word closes first, then the operator token.
              bundle.count      = 2'd3;
              bundle.slot[0]    = mk_res(EV_CLOSE, 8'h00, KIND_WORD, ERR_MULTI);
              bundle.slot[1]    = mk_res(EV_VALUE, c, KIND_QUOTED, ERR_MULTI);
              bundle.slot[2]    = mk_res(EV_CLOSE, 8'h00, KIND_OPER, ERR_MULTI);
              have_operand_next = 1'b0;
              mode_next         = ST_START;
              if (c == CH_PIPE) seen_pipe_next = 1'b1;
              if (c == CH_GT) seen_out_redirect_next = 1'b1;
            end
          end else if (is_prn) begin
            bundle.count   = 2'd1;
            bundle.slot[0] = mk_res(EV_VALUE, c, KIND_QUOTED, ERR_MULTI);
          end else begin
            bundle.count        = 2'd1;
            bundle.slot[0]      = mk_res(EV_ERROR, 8'h00, KIND_QUOTED, ERR_NPRINT);
            line_reset          = 1'b1;
            discard_to_eol_next = 1'b1;
          end
        end
        default: begin
          if (is_eol) begin
            bundle.count   = 2'd1;
            bundle.slot[0] = mk_res(EV_ACCEPT, 8'h00, KIND_QUOTED, ERR_MULTI);
            line_reset     = 1'b1;
          end else if (is_blank) begin
            mode_next = ST_START;
          end else if (c == CH_DQUOTE) begin
            mode_next = ST_QUOTE;
          end else if (is_oper) begin
            if (!have_operand || ((c == CH_PIPE) && seen_out_redirect)) begin
              bundle.count        = 2'd1;
              bundle.slot[0]      = mk_res(EV_ERROR, 8'h00, KIND_QUOTED, ERR_OPERAND);
              line_reset          = 1'b1;
              discard_to_eol_next = 1'b1;
            end else if ((c == CH_LT) && seen_pipe) begin
              bundle.count        = 2'd1;
              bundle.slot[0]      = mk_res(EV_ERROR, 8'h00, KIND_QUOTED, ERR_MULTI);
              line_reset          = 1'b1;
              discard_to_eol_next = 1'b1;
            end else begin
              bundle.count      = 2'd2;
              bundle.slot[0]    = mk_res(EV_VALUE, c, KIND_QUOTED, ERR_MULTI);
              bundle.slot[1]    = mk_res(EV_CLOSE, 8'h00, KIND_OPER, ERR_MULTI);
              have_operand_next = 1'b0;
              mode_next         = ST_START;
              if (c == CH_PIPE) seen_pipe_next = 1'b1;
              if (c == CH_GT) seen_out_redirect_next = 1'b1;
            end
          end else if (is_prn) begin
            bundle.count   = 2'd1;
            bundle.slot[0] = mk_res(EV_VALUE, c, KIND_QUOTED, ERR_MULTI);
            mode_next      = ST_WORD;
          end else begin
            bundle.count        = 2'd1;
            bundle.slot[0]      = mk_res(EV_ERROR, 8'h00, KIND_QUOTED, ERR_NPRINT);
            line_reset          = 1'b1;
            discard_to_eol_next = 1'b1;
          end
        end
      endcase
    end

    if (line_reset) begin
      mode_next              = ST_START;
      seen_pipe_next         = 1'b0;
      seen_out_redirect_next = 1'b0;
      have_operand_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= ST_START;
      seen_pipe         <= 1'b0;
      seen_out_redirect <= 1'b0;
      have_operand      <= 1'b0;
      discard_to_eol    <= 1'b0;
    end else if (accept) begin
      mode              <= mode_next;
      seen_pipe         <= seen_pipe_next;
      seen_out_redirect <= seen_out_redirect_next;
      have_operand      <= have_operand_next;
      discard_to_eol    <= discard_to_eol_next;
    end
  end

endmodule

// ----- rtl/core/shlex_queue.sv -----
module shlex_queue #(
  parameter int Depth = shlex_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  shlex_pkg::bundle_t push_data,
  output logic               full,
  input  logic               pop,
  output shlex_pkg::bundle_t head,
  output logic               empty
);
  import shlex_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bundle_t             store [Depth];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     fill;
  logic                do_push, do_pop;

  assign full    = (fill == CntW'(Depth));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/core/shlex_back.sv -----
module shlex_back (
  input  logic               clk,
  input  logic               rst,
  input  shlex_pkg::bundle_t head,
  input  logic               empty,
  output logic               pop,
  shlex_res_if.source        results
);
  import shlex_pkg::*;

  logic [1:0] idx;
  logic       out_valid;
  res_t       out_res;
  logic       out_last;
  logic       load;
  logic       final_slot;

  assign load       = !empty && (!out_valid || results.ready);
  assign final_slot = (idx == (head.count - 2'd1));
  assign pop        = load && final_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_slot ? 2'd0 : idx + 2'd1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= head.slot[idx];
      out_last <= final_slot;
    end
  end

  assign results.valid      = out_valid;
  assign results.event_res  = out_res.ev;
  assign results.value_byte = out_res.value_byte;
  assign results.token_kind = out_res.kind;
  assign results.error_code = out_res.err;
  assign results.last       = out_last;

endmodule

// ----- rtl/core/shell_command_line_lexer.sv -----
// Command-line lexer.
// Bytes of a command line enter on the chars channel, one byte per handshake;
// 0x0A or 0x00 ends a line. Every byte gives zero to three result words on the
// results channel: token value bytes, token-closed events with their kind,
// line accepted, or line error with a code. The last field marks the final
// result word of each byte; bytes that give no result (blanks, opening quotes,
// dropped bytes after an error) leave no trace on the output.
// A front stage runs the lexer automaton and accepts one byte per cycle while
// the queue is not full; it packs all results of a byte into one bundle and
// writes it to a queue of QueueDepth bundles. A back stage reads the queue and
// sends one result word per cycle while the receiver is ready; a byte's bundle
// is registered in the queue before the back stage loads its first result word
// into the registered output stage. Throughput: one byte per cycle while bytes
// give at most one result each and the receiver is ready; the words of a byte
// with two or three results go out one after another, and the queue absorbs
// the bursts. When the receiver stalls, the queue fills and chars.ready falls
// until space returns; nothing is dropped. Synchronous reset empties the queue
// and output stage and puts the lexer at the start of a fresh line.
module shell_command_line_lexer #(
  parameter int QueueDepth = shlex_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  shlex_char_if.sink  chars,
  shlex_res_if.source results
);
  import shlex_pkg::*;

  // Bundles travel from the front to the back through the queue.
  bundle_t push_data;
  bundle_t head;
  logic    push, full, pop, empty;

  shlex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  shlex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  shlex_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

endmodule

// ----- rtl/core/shlex_checker.sv -----
module shlex_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] event_res,
  input logic [7:0] value_byte,
  input logic [1:0] token_kind,
  input logic [1:0] error_code,
  input logic       last
);
  import shlex_pkg::*;

  // A stalled result word stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word withdrawn under stall");

  // A stalled result word keeps its payload.
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      $stable({event_res, value_byte, token_kind, error_code, last}))
    else $error("result payload changed under stall");

  // Reset leaves no result word on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result word present after reset");

  // Line acceptance and line errors always end the results of their byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_ACCEPT || event_res == EV_ERROR) |-> last)
    else $error("line end event not marked last");

  // Only value events carry a byte, and no token kind beyond operator exists.
  a_clean_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (event_res == EV_VALUE || value_byte == 8'h00) &&
                  (token_kind != 2'd3))
    else $error("stray payload on result word");

endmodule

bind shell_command_line_lexer shlex_checker u_shlex_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .event_res  (results.event_res),
  .value_byte (results.value_byte),
  .token_kind (results.token_kind),
  .error_code (results.error_code),
  .last       (results.last)
);
